// ===== hdl/gcf_pkg.sv =====
// shared types, constants and elaboration helpers for the graphlet canonical form core
// no dependencies; imported by every module of the block
package gcf_pkg;

  localparam int NODES_DEF  = 8;
  localparam int GRAPH_W    = 28;
  localparam int CANON_W    = 28;
  localparam int IDX_OUT_W  = 16;
  localparam int DIGITS_W   = 24;
  localparam int DIGIT_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOWER_ORDER = 2'd0,
    CFG_INVERT_PERM = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RELOAD,
    ST_MATCH,
    ST_DONE
  } gcf_state_t;

  typedef struct packed {
    logic restart;
    logic advance;
  } pg_ctrl_t;

  function automatic int fact(int n);
    int r;
    int k;
    r = 1;
    for (k = 2; k <= n; k++) begin
      r = r * k;
    end
    return r;
  endfunction

  // vertex of pair idx in the chosen triangle order; second selects the column vertex
  function automatic int pair_vertex(int idx, int nodes, bit lower, bit second);
    int n;
    int i;
    int j;
    int v;
    n = 0;
    v = 0;
    if (lower) begin
      for (i = 1; i < nodes; i++) begin
        for (j = 0; j < i; j++) begin
          if (n == idx) begin
            v = second ? j : i;
          end
          n++;
        end
      end
    end else begin
      for (i = 0; i + 1 < nodes; i++) begin
        for (j = i + 1; j < nodes; j++) begin
          if (n == idx) begin
            v = second ? j : i;
          end
          n++;
        end
      end
    end
    return v;
  endfunction

endpackage

// ===== hdl/gcf_pack_unit.sv =====
// shared relabel unit: holds an adjacency matrix and packs it under the current permutation
// depends on gcf_pkg for the pair order helpers
module gcf_pack_unit import gcf_pkg::*; #(
  parameter int NODES = NODES_DEF,
  localparam int PAIRS = NODES * (NODES - 1) / 2,
  localparam int VW = $clog2(NODES)
) (
  input  logic                clk,
  input  logic                load,
  input  logic [PAIRS-1:0]    load_bits,
  input  logic                lower_order,
  input  logic [NODES*VW-1:0] perm,
  output logic [PAIRS-1:0]    packed_bits
);

  logic [NODES-1:0][NODES-1:0] adj_r;
  logic [NODES-1:0][NODES-1:0] adj_nxt;
  logic [VW-1:0]               pa_sel [PAIRS];
  logic [VW-1:0]               pb_sel [PAIRS];
  logic [VW-1:0]               pv     [NODES];

  for (genvar n = 0; n < PAIRS; n++) begin : g_pair
    localparam int UA = pair_vertex(n, NODES, 1'b0, 1'b0);
    localparam int UB = pair_vertex(n, NODES, 1'b0, 1'b1);
    localparam int LA = pair_vertex(n, NODES, 1'b1, 1'b0);
    localparam int LB = pair_vertex(n, NODES, 1'b1, 1'b1);
    assign pa_sel[n] = lower_order ? VW'(LA) : VW'(UA);
    assign pb_sel[n] = lower_order ? VW'(LB) : VW'(UB);
  end

  for (genvar k = 0; k < NODES; k++) begin : g_vtx
    assign pv[k] = perm[k*VW +: VW];
  end

  // unpack edge bits, first pair in the top bit
  always_comb begin
    adj_nxt = '0;
    for (int n = 0; n < PAIRS; n++) begin
      adj_nxt[pa_sel[n]][pb_sel[n]] = load_bits[PAIRS-1-n];
      adj_nxt[pb_sel[n]][pa_sel[n]] = load_bits[PAIRS-1-n];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      adj_r <= adj_nxt;
    end
  end

  always_comb begin
    packed_bits = '0;
    for (int n = 0; n < PAIRS; n++) begin
      packed_bits[PAIRS-1-n] = adj_r[pv[pa_sel[n]]][pv[pb_sel[n]]];
    end
  end

endmodule

// ===== hdl/gcf_perm_gen.sv =====
// permutation sequencer: steps through all vertex relabelings in lexicographic order
// depends on gcf_pkg for the control struct and factorial helper
module gcf_perm_gen import gcf_pkg::*; #(
  parameter int NODES = NODES_DEF,
  localparam int VW = $clog2(NODES),
  localparam int NPERM = fact(NODES),
  localparam int IDX_W = $clog2(NPERM)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pg_ctrl_t            ctrl,
  output logic [NODES*VW-1:0] perm,
  output logic [IDX_W-1:0]    idx,
  output logic                last
);

  typedef logic [NODES-1:0][VW-1:0] perm_t;

  perm_t            perm_r;
  perm_t            perm_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;

  function automatic perm_t identity_perm();
    perm_t q;
    for (int k = 0; k < NODES; k++) begin
      q[k] = VW'(k);
    end
    return q;
  endfunction

  function automatic perm_t next_perm(perm_t p);
    int    piv;
    int    sw;
    perm_t s;
    perm_t q;
    piv = -1;
    sw  = 0;
    for (int k = 0; k + 1 < NODES; k++) begin
      if (p[k] < p[k+1]) begin
        piv = k;
      end
    end
    q = p;
    if (piv >= 0) begin
      for (int k = 0; k < NODES; k++) begin
        if (k > piv && p[k] > p[piv]) begin
          sw = k;
        end
      end
      s      = p;
      s[piv] = p[sw];
      s[sw]  = p[piv];
      q      = s;
      // reverse the suffix after the pivot
      for (int k = 0; k < NODES; k++) begin
        if (k > piv) begin
          q[k] = s[NODES + piv - k];
        end
      end
    end
    return q;
  endfunction

  always_comb begin
    perm_nxt = perm_r;
    idx_nxt  = idx_r;
    priority if (ctrl.restart) begin
      perm_nxt = identity_perm();
      idx_nxt  = '0;
    end else if (ctrl.advance) begin
      perm_nxt = next_perm(perm_r);
      idx_nxt  = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perm_r <= identity_perm();
      idx_r  <= '0;
    end else begin
      perm_r <= perm_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign perm = perm_r;
  assign idx  = idx_r;
  assign last = (idx_r == IDX_W'(NPERM - 1));

endmodule

// ===== hdl/graphlet_canonical_form_core.sv =====
// one transaction at a time: the input stalls from an accept until its result loads
// both passes step the permutation sequencer once a cycle through the shared pack unit
// a held result does not block the next input, only the loading of the next result
// reset: synchronous active-low rst_n clears the sequencer, output valid and both config registers
module graphlet_canonical_form_core import gcf_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [GRAPH_W-1:0]    in_graph_bits,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CANON_W-1:0]    out_canonical_bits,
  output logic [IDX_OUT_W-1:0]  out_perm_index,
  output logic [DIGITS_W-1:0]   out_perm_digits,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PAIRS = NODES * (NODES - 1) / 2;
  localparam int VW    = $clog2(NODES);
  localparam int NPERM = fact(NODES);
  localparam int IDX_W = $clog2(NPERM);

  gcf_state_t state_r;
  gcf_state_t state_nxt;

  logic lower_order_r;
  logic lower_order_nxt;
  logic invert_perm_r;
  logic invert_perm_nxt;

  logic [PAIRS-1:0]            g_r;
  logic [PAIRS-1:0]            best_r;
  logic [NODES-1:0][VW-1:0]    found_perm_r;
  logic [NODES-1:0][VW-1:0]    found_perm_nxt;
  logic [NODES-1:0][VW-1:0]    ident;
  logic [NODES-1:0][VW-1:0]    rep;
  logic [IDX_W-1:0]            found_idx_r;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [CANON_W-1:0]          out_canon_r;
  logic [IDX_OUT_W-1:0]        out_idx_r;
  logic [DIGITS_W-1:0]         out_digits_r;
  logic [DIGITS_W-1:0]         digits_nxt;

  logic                  in_accept;
  logic                  out_free;
  logic                  hit;
  pg_ctrl_t              pg_ctrl;
  logic [NODES*VW-1:0]   pg_perm;
  logic [IDX_W-1:0]      pg_idx;
  logic                  pg_last;
  logic                  pk_load;
  logic                  pk_src_best;
  logic [PAIRS-1:0]      pk_load_bits;
  logic [PAIRS-1:0]      pk_bits;
  logic                  best_upd;
  logic                  found_cap;
  logic                  out_load;

  gcf_perm_gen #(.NODES(NODES)) u_perm_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (pg_ctrl),
    .perm  (pg_perm),
    .idx   (pg_idx),
    .last  (pg_last)
  );

  assign pk_load_bits = pk_src_best ? best_r : in_graph_bits[PAIRS-1:0];

  gcf_pack_unit #(.NODES(NODES)) u_pack_unit (
    .clk         (clk),
    .load        (pk_load),
    .load_bits   (pk_load_bits),
    .lower_order (lower_order_r),
    .perm        (pg_perm),
    .packed_bits (pk_bits)
  );

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign hit       = (pk_bits == g_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_accept) state_nxt = ST_SCAN;
      ST_SCAN:   if (pg_last) state_nxt = ST_RELOAD;
      ST_RELOAD: state_nxt = ST_MATCH;
      ST_MATCH:  if (hit || pg_last) state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    pg_ctrl     = '0;
    pk_load     = 1'b0;
    pk_src_best = 1'b0;
    best_upd    = 1'b0;
    found_cap   = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall        = 1'b0;
        pk_load         = in_accept;
        pg_ctrl.restart = in_accept;
      end
      ST_SCAN: begin
        best_upd        = (pk_bits < best_r);
        pg_ctrl.advance = !pg_last;
      end
      ST_RELOAD: begin
        pk_load         = 1'b1;
        pk_src_best     = 1'b1;
        pg_ctrl.restart = 1'b1;
      end
      ST_MATCH: begin
        found_cap       = hit || pg_last;
        pg_ctrl.advance = !hit && !pg_last;
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < NODES; k++) begin
      ident[k] = VW'(k);
    end
  end

  assign found_perm_nxt = hit ? pg_perm : ident;

  // inverse relabeling when asked for
  always_comb begin
    rep = found_perm_r;
    if (invert_perm_r) begin
      rep = '0;
      for (int k = 0; k < NODES; k++) begin
        for (int i = 0; i < NODES; i++) begin
          if (found_perm_r[i] == VW'(k)) begin
            rep[k] = rep[k] | VW'(i);
          end
        end
      end
    end
  end

  always_comb begin
    digits_nxt = '0;
    for (int i = 0; i < NODES; i++) begin
      digits_nxt[DIGIT_W*(NODES-1-i) +: DIGIT_W] = DIGIT_W'(rep[i]);
    end
  end

  always_comb begin
    lower_order_nxt = lower_order_r;
    invert_perm_nxt = invert_perm_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_LOWER_ORDER: lower_order_nxt = cfg_wdata[0];
        CFG_INVERT_PERM: invert_perm_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      lower_order_r <= 1'b0;
      invert_perm_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      lower_order_r <= lower_order_nxt;
      invert_perm_r <= invert_perm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      g_r    <= in_graph_bits[PAIRS-1:0];
      best_r <= in_graph_bits[PAIRS-1:0];
    end else if (best_upd) begin
      best_r <= pk_bits;
    end
    if (found_cap) begin
      found_perm_r <= found_perm_nxt;
      found_idx_r  <= hit ? pg_idx : '0;
    end
    if (out_load) begin
      out_canon_r  <= CANON_W'(best_r);
      out_idx_r    <= IDX_OUT_W'(found_idx_r);
      out_digits_r <= digits_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_canonical_bits = out_canon_r;
  assign out_perm_index     = out_idx_r;
  assign out_perm_digits    = out_digits_r;

endmodule

// ===== hdl/gcf_checker.sv =====
// port-level checks for the graphlet canonical form core, bound to the top level
// depends on gcf_pkg for widths and the factorial helper
module gcf_checker import gcf_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [CANON_W-1:0]    out_canonical_bits,
  input logic [IDX_OUT_W-1:0]  out_perm_index,
  input logic [DIGITS_W-1:0]   out_perm_digits
);

  localparam int NPERM = fact(NODES);

  // one transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // both relabeling passes lie between an accept and its result, so no result can follow an accept at once
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_canonical_bits)
      && $stable(out_perm_index) && $stable(out_perm_digits))
    else $error("stalled result changed");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_perm_index < IDX_OUT_W'(NPERM))
    else $error("permutation index out of range");

endmodule

bind graphlet_canonical_form_core gcf_checker #(.NODES(NODES)) u_gcf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_canonical_bits (out_canonical_bits),
  .out_perm_index     (out_perm_index),
  .out_perm_digits    (out_perm_digits)
);

// ===== dv/graphlet_canon_checker.sv =====
// result checker for graphlet_canonical_form_core: mirrors the two config registers,
// predicts canonical form and relabeling per accepted graph, compares each result in order
// depends on gcf_pkg for widths and register codes
module graphlet_canon_checker import gcf_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [GRAPH_W-1:0]    in_graph_bits,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [CANON_W-1:0]    out_canonical_bits,
  input  logic [IDX_OUT_W-1:0]  out_perm_index,
  input  logic [DIGITS_W-1:0]   out_perm_digits,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAIRS = NODES * (NODES - 1) / 2;
  localparam logic [GRAPH_W-1:0] GMASK = GRAPH_W'((64'd1 << PAIRS) - 64'd1);

  typedef logic [NODES*NODES-1:0] adj_vec_t;
  typedef logic [3*NODES-1:0]     perm_vec_t;

  typedef struct packed {
    logic [GRAPH_W-1:0]   graph;
    logic [CANON_W-1:0]   canon;
    logic [IDX_OUT_W-1:0] index;
    logic [DIGITS_W-1:0]  digits;
  } canon_result_t;

  int            pair_a [PAIRS];
  int            pair_b [PAIRS];
  logic          lower_q;
  logic          invert_q;
  canon_result_t canon_q [$];

  function automatic adj_vec_t unpack_edges(logic [GRAPH_W-1:0] g);
    adj_vec_t a;
    int       n;
    a = '0;
    for (n = 0; n < PAIRS; n++) begin
      a[pair_a[n]*NODES + pair_b[n]] = g[PAIRS-1-n];
      a[pair_b[n]*NODES + pair_a[n]] = g[PAIRS-1-n];
    end
    return a;
  endfunction

  function automatic logic [GRAPH_W-1:0] relabel(adj_vec_t a, perm_vec_t p);
    logic [GRAPH_W-1:0] v;
    int                 n;
    v = '0;
    for (n = 0; n < PAIRS; n++) begin
      v = {v[GRAPH_W-2:0],
           a[int'(p[3*pair_a[n] +: 3])*NODES + int'(p[3*pair_b[n] +: 3])]};
    end
    return v;
  endfunction

  function automatic perm_vec_t identity_perm();
    perm_vec_t p;
    int        k;
    for (k = 0; k < NODES; k++) begin
      p[3*k +: 3] = k[2:0];
    end
    return p;
  endfunction

  // next permutation in lexicographic order, 0 after the last one
  function automatic bit step_perm(inout perm_vec_t p);
    int         i;
    int         j;
    int         a;
    int         b;
    logic [2:0] t;
    i = NODES - 2;
    while (i >= 0 && p[3*i +: 3] >= p[3*(i+1) +: 3]) i--;
    if (i < 0) return 1'b0;
    j = NODES - 1;
    while (p[3*j +: 3] <= p[3*i +: 3]) j--;
    t = p[3*i +: 3];
    p[3*i +: 3] = p[3*j +: 3];
    p[3*j +: 3] = t;
    for (a = i + 1, b = NODES - 1; a < b; a++, b--) begin
      t = p[3*a +: 3];
      p[3*a +: 3] = p[3*b +: 3];
      p[3*b +: 3] = t;
    end
    return 1'b1;
  endfunction

  function automatic canon_result_t predict_canon(logic [GRAPH_W-1:0] g_raw);
    canon_result_t      r;
    adj_vec_t           adj;
    adj_vec_t           cadj;
    perm_vec_t          p;
    perm_vec_t          found;
    perm_vec_t          rep;
    logic [GRAPH_W-1:0] g;
    logic [GRAPH_W-1:0] best;
    logic [GRAPH_W-1:0] v;
    int                 n;
    int                 i;
    int                 j;
    int                 idx;
    int                 hit;
    bit                 more;
    n = 0;
    if (lower_q) begin
      for (i = 1; i < NODES; i++) begin
        for (j = 0; j < i; j++) begin
          pair_a[n] = i;
          pair_b[n] = j;
          n++;
        end
      end
    end else begin
      for (i = 0; i + 1 < NODES; i++) begin
        for (j = i + 1; j < NODES; j++) begin
          pair_a[n] = i;
          pair_b[n] = j;
          n++;
        end
      end
    end
    g = g_raw & GMASK;
    adj = unpack_edges(g);
    best = g;
    p = identity_perm();
    more = 1'b1;
    while (more) begin
      v = relabel(adj, p);
      if (v < best) best = v;
      more = step_perm(p);
    end
    // first relabeling that carries the canonical form back onto the input
    cadj = unpack_edges(best);
    p = identity_perm();
    found = p;
    idx = 0;
    hit = 0;
    more = 1'b1;
    while (more) begin
      if (relabel(cadj, p) == g) begin
        found = p;
        hit = idx;
        more = 1'b0;
      end else begin
        idx++;
        more = step_perm(p);
      end
    end
    rep = found;
    if (invert_q) begin
      for (i = 0; i < NODES; i++) begin
        rep[3*int'(found[3*i +: 3]) +: 3] = i[2:0];
      end
    end
    r.graph = g_raw;
    r.canon = best;
    r.index = IDX_OUT_W'(hit);
    r.digits = '0;
    for (i = 0; i < NODES; i++) begin
      r.digits[3*(NODES-1-i) +: 3] = rep[3*i +: 3];
    end
    return r;
  endfunction

  task automatic compare_field(input logic [GRAPH_W-1:0] graph, input string field,
                               input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("graph %h: %s expected %h, got %h", graph, field, want, got);
      end
    end
  endtask

  initial begin
    mismatches = 0;
    outstanding = 0;
    lower_q = 1'b0;
    invert_q = 1'b0;
  end

  always @(posedge clk) begin
    canon_result_t exp_r;
    if (!rst_n) begin
      lower_q = 1'b0;
      invert_q = 1'b0;
      canon_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (canon_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result with no transaction pending: canonical %h index %0d digits %h",
                     out_canonical_bits, out_perm_index, out_perm_digits);
          end
        end else begin
          exp_r = canon_q.pop_front();
          compare_field(exp_r.graph, "canonical_bits", 32'(exp_r.canon),
                        32'(out_canonical_bits));
          compare_field(exp_r.graph, "perm_index", 32'(exp_r.index), 32'(out_perm_index));
          compare_field(exp_r.graph, "perm_digits", 32'(exp_r.digits), 32'(out_perm_digits));
        end
      end
      if (in_valid && !in_stall) begin
        canon_q.push_back(predict_canon(in_graph_bits));
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOWER_ORDER: lower_q = cfg_wdata[0];
          CFG_INVERT_PERM: invert_q = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    outstanding = canon_q.size();
  end

endmodule

// ===== dv/tb_graphlet_canonical_form_core.sv =====
// top-level testbench for graphlet_canonical_form_core: clock, reset, graph and config stimulus,
// random output stalls; result checking lives in graphlet_canon_checker
// depends on gcf_pkg, graphlet_canonical_form_core and graphlet_canon_checker
module tb_graphlet_canonical_form_core;
  timeunit 1ns;
  timeprecision 1ps;
  import gcf_pkg::*;

  localparam int NODES        = NODES_DEF;
  localparam int LATENCY      = 2 * fact(NODES) + 3;
  localparam int HOLD_CYCLES  = 200000;
  localparam int PHASE_ITEMS  = 25;
  localparam int CALM_ITEMS   = 10;
  localparam int DIR_ITEMS    = 20;
  localparam int DIR_SPLIT    = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED3 = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [GRAPH_W-1:0]    in_graph_bits;
  logic                  out_valid;
  logic                  out_stall;
  logic [CANON_W-1:0]    out_canonical_bits;
  logic [IDX_OUT_W-1:0]  out_perm_index;
  logic [DIGITS_W-1:0]   out_perm_digits;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatches;
  int                    outstanding;
  bit                    calm;
  bit                    hold_req;
  logic [GRAPH_W-1:0]    dir_list [DIR_ITEMS];

  graphlet_canonical_form_core #(.NODES(NODES)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_graph_bits      (in_graph_bits),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_canonical_bits (out_canonical_bits),
    .out_perm_index     (out_perm_index),
    .out_perm_digits    (out_perm_digits),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  graphlet_canon_checker #(.NODES(NODES)) canon_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_graph_bits      (in_graph_bits),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_canonical_bits (out_canonical_bits),
    .out_perm_index     (out_perm_index),
    .out_perm_digits    (out_perm_digits),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .mismatches         (mismatches),
    .outstanding        (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_graph(input logic [GRAPH_W-1:0] g);
    @(negedge clk);
    in_valid = 1'b1;
    in_graph_bits = g;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!calm && $urandom_range(0, 1) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 14)) @(negedge clk);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // receiver side stalls
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        hold_req = 1'b0;
      end else if (calm || !rst_n) begin
        out_stall = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        n = $urandom_range(1, 15);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_stall = 1'b0;
        n = $urandom_range(1, 40);
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  initial begin
    logic [GRAPH_W-1:0] g;
    int                 phase;
    int                 k;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_graph_bits = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_LOWER_ORDER;
    cfg_wdata = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    dir_list = '{28'h0000000, 28'hFFFFFFF, 28'h8000000, 28'h0000001, 28'hAAAAAAA,
                 28'h5555555, 28'hFFFFFFE, 28'h7FFFFFF, 28'hFE00000, 28'h0F0F0F0,
                 28'h1234567, 28'h0000003,
                 28'h0000000, 28'hFFFFFFF, 28'h8000000, 28'h0000001, 28'hAAAAAAA,
                 28'h7FFFFFF, 28'h8000001, 28'hEDCBA98};
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    write_reg(CFG_LOWER_ORDER, 1'b0);
    write_reg(CFG_INVERT_PERM, 1'b0);
    for (k = 0; k < DIR_ITEMS; k++) begin
      if (k == DIR_SPLIT) begin
        settle();
        write_reg(CFG_LOWER_ORDER, 1'b1);
        write_reg(CFG_INVERT_PERM, 1'b1);
      end
      send_graph(dir_list[k]);
    end

    for (phase = 0; phase < 4; phase++) begin
      settle();
      write_reg(CFG_LOWER_ORDER, (phase == 0 || phase == 3) ? 1'b1 : 1'b0);
      write_reg(CFG_INVERT_PERM, (phase == 1 || phase == 3) ? 1'b1 : 1'b0);
      if (phase == 1) begin
        // unmapped indexes must leave both registers alone
        write_reg(CFG_IDX_UNUSED2, 1'b1);
        write_reg(CFG_IDX_UNUSED3, 1'b1);
        hold_req = 1'b1;
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 2 && k == PHASE_ITEMS / 2) begin
          settle();
          repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        if (phase == 3 && k == PHASE_ITEMS - CALM_ITEMS) calm = 1'b1;
        case ($urandom_range(0, 3))
          0: g = GRAPH_W'($urandom());
          1: g = GRAPH_W'($urandom() & $urandom() & $urandom());
          2: g = GRAPH_W'($urandom() | $urandom() | $urandom());
          default: g = (GRAPH_W'(1) << $urandom_range(0, GRAPH_W - 1)) |
                       (GRAPH_W'(1) << $urandom_range(0, GRAPH_W - 1));
        endcase
        send_graph(g);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/gcf_pkg.sv
hdl/gcf_pack_unit.sv
hdl/gcf_perm_gen.sv
hdl/graphlet_canonical_form_core.sv
hdl/gcf_checker.sv
dv/graphlet_canon_checker.sv
dv/tb_graphlet_canonical_form_core.sv
